[hw/rtl/bba_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the block bitmap allocator.
// No dependencies; the allocator unit and bba_first_zero import this package.
package bba_pkg;

   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned BYTES_PER_WORD = WORD_BITS / BYTE_BITS;
   localparam int unsigned BLK_W = 10;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned CFG_W = 10;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_READ,
      CMD_MARK
   } bba_cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE,
      STAT_NO_FREE,
      STAT_IGNORED
   } bba_status_type;

   typedef enum logic {
      REG_DATA_FIRST,
      REG_DATA_LAST
   } bba_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOOK,
      ST_RESULT
   } bba_state_type;

   // first clear bit of one map word
   typedef struct packed {
      logic       found;
      logic [5:0] idx;
   } bba_find_type;

endpackage

[hw/rtl/bba_req_if.sv]
`timescale 1ns / 1ps
// Command channel of the block bitmap allocator: valid, ready and one command word.
// Stand-alone; no package needed.
interface bba_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [9:0] block_number;

   modport source (output valid, output command, output block_number, input ready);
   modport sink (input valid, input command, input block_number, output ready);
endinterface

[hw/rtl/bba_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the block bitmap allocator: valid, ready and one result word.
// Stand-alone; no package needed.
interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  result_block;
   logic [1:0]  status;
   logic        bit_value;
   logic [10:0] free_count;

   modport source (output valid, output result_block, output status, output bit_value,
                   output free_count, input ready);
   modport sink (input valid, input result_block, input status, input bit_value,
                 input free_count, output ready);
endinterface

[hw/rtl/block_bitmap_allocator_unit.sv]
`timescale 1ns / 1ps
// Block bitmap allocator, first fit, map held as 64-bit words in one RAM.
// Free, read and mark read the addressed word if in the map and form the result; allocate scans
// map words from the first until one has a clear bit (1 to ceil(NUM_BLOCKS/64), 16 by default),
// one word per cycle through the RAM read port. Allocate with no free block skips the scan.
// One command at a time; the next is taken once its result sits in the output register.
// Reset: a clearing pass writes ceil(NUM_BLOCKS/64) words (16 by default), no command taken.
module block_bitmap_allocator_unit #(
   parameter int unsigned NUM_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   bba_req_if.sink     req_ch,
   bba_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);
   import bba_pkg::*;

   localparam int unsigned ROWS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned FW = $clog2(NUM_BLOCKS + 1);
   localparam int unsigned FEW = (FW > COUNT_W) ? FW : COUNT_W;
   localparam int unsigned NW = AW + 6;
   localparam int unsigned NEW = (NW > BLK_W) ? NW : BLK_W;
   localparam int unsigned LAST_VALID = NUM_BLOCKS - WORD_BITS * (ROWS - 1);
   localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
   localparam logic [FW-1:0] FREE_MAX = FW'(NUM_BLOCKS);
   localparam logic [16:0] NUM_BLOCKS_EXT = 17'(NUM_BLOCKS);
   localparam logic [63:0] LAST_ONE = 64'd1 << LAST_VALID;
   // bits of the last word that lie beyond the map count as used
   localparam logic [63:0] LAST_PAD = ~(LAST_ONE - 64'd1);

   bba_state_type  state_ff, state_in;
   bba_cmd_type    cmd_ff, cmd_in;
   logic [9:0]     blk_ff, blk_in;
   logic [AW-1:0]  row_ff, row_in;
   logic [FW-1:0]  free_ff, free_in;
   logic [9:0]     data_first_ff, data_last_ff;
   logic [9:0]     res_blk_ff, res_blk_in;
   bba_status_type res_stat_ff, res_stat_in;
   logic           res_bit_ff, res_bit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [9:0]     rsp_blk_ff;
   bba_status_type rsp_stat_ff;
   logic           rsp_bit_ff;
   logic [10:0]    rsp_free_ff;

   logic           accept;
   logic           out_free;
   logic           inmap;
   logic [16:0]    req_blk_ext;
   logic           mem_wr_en;
   logic [AW-1:0]  mem_wr_addr;
   logic [63:0]    mem_wr_data;
   logic [AW-1:0]  mem_rd_addr;
   logic [63:0]    mem_rd_data;
   logic [63:0]    scan_word;
   bba_find_type   find;
   logic [NW-1:0]  found_blk;
   logic [NEW-1:0] found_blk_ext;
   logic [FEW-1:0] free_ext;
   logic           look_bit;
   logic [63:0]    look_mask;
   logic           free_ok;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_blk_ext  = 17'(req_ch.block_number);
   assign inmap        = req_blk_ext < NUM_BLOCKS_EXT;

   assign scan_word     = mem_rd_data | ((row_ff == LAST_ROW) ? LAST_PAD : 64'd0);
   assign found_blk     = {row_ff, find.idx};
   assign found_blk_ext = NEW'(found_blk);
   assign look_bit      = mem_rd_data[blk_ff[5:0]];
   assign look_mask     = 64'd1 << blk_ff[5:0];
   assign free_ok       = (blk_ff != 10'd0) && (data_first_ff <= blk_ff)
                          && (blk_ff <= data_last_ff) && look_bit;
   assign free_ext      = FEW'(free_ff);

   bba_first_zero u_first_zero (
      .word (scan_word),
      .find (find)
   );

   bba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS),
      .ADDR_W(AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (bba_cmd_type'(req_ch.command) == CMD_ALLOC) begin
                  state_in = (free_ff == '0) ? ST_RESULT : ST_SCAN;
               end else begin
                  state_in = inmap ? ST_LOOK : ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (find.found || row_ff == LAST_ROW) begin
               state_in = ST_RESULT;
            end
         end
         ST_LOOK: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cmd_in       = cmd_ff;
      blk_in       = blk_ff;
      row_in       = row_ff;
      free_in      = free_ff;
      res_blk_in   = res_blk_ff;
      res_stat_in  = res_stat_ff;
      res_bit_in   = res_bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = row_ff;
      mem_wr_data  = '0;
      mem_rd_addr  = row_ff + AW'(1);
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            row_in    = row_ff + AW'(1);
         end
         ST_IDLE: begin
            cmd_in = bba_cmd_type'(req_ch.command);
            blk_in = req_ch.block_number;
            row_in = '0;
            if (bba_cmd_type'(req_ch.command) == CMD_ALLOC) begin
               mem_rd_addr = '0;
               res_blk_in  = '0;
               res_stat_in = STAT_NO_FREE;
               res_bit_in  = 1'b0;
            end else begin
               mem_rd_addr = inmap ? req_blk_ext[AW+5:6] : '0;
               res_blk_in  = req_ch.block_number;
               res_bit_in  = 1'b0;
               res_stat_in = (bba_cmd_type'(req_ch.command) == CMD_READ) ? STAT_DONE
                                                                          : STAT_IGNORED;
            end
         end
         ST_SCAN: begin
            if (find.found) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = mem_rd_data | (64'd1 << find.idx);
               free_in     = free_ff - FW'(1);
               res_blk_in  = found_blk_ext[9:0];
               res_stat_in = STAT_DONE;
            end else begin
               // prefetch of the next word is already under way
               row_in = row_ff + AW'(1);
            end
         end
         ST_LOOK: begin
            mem_wr_addr = row_ff;
            res_blk_in  = blk_ff;
            res_bit_in  = look_bit;
            res_stat_in = STAT_DONE;
            case (cmd_ff)
               CMD_FREE: begin
                  if (free_ok) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = mem_rd_data & ~look_mask;
                     if (free_ff < FREE_MAX) begin
                        free_in = free_ff + FW'(1);
                     end
                  end else begin
                     res_stat_in = STAT_IGNORED;
                  end
               end
               CMD_MARK: begin
                  if (!look_bit) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = mem_rd_data | look_mask;
                     if (free_ff != '0) begin
                        free_in = free_ff - FW'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // state, row, free count, result valid, data range; free, read and mark load their block's row
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         row_ff        <= '0;
         free_ff       <= FREE_MAX;
         data_first_ff <= '0;
         data_last_ff  <= 10'd1023;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= (state_ff == ST_IDLE && cmd_in != CMD_ALLOC) ?
                         req_blk_ext[AW+5:6] : row_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (bba_reg_type'(csr_index))
               REG_DATA_FIRST: data_first_ff <= csr_wdata;
               REG_DATA_LAST:  data_last_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      blk_ff      <= blk_in;
      res_blk_ff  <= res_blk_in;
      res_stat_ff <= res_stat_in;
      res_bit_ff  <= res_bit_in;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_blk_ff  <= res_blk_ff;
         rsp_stat_ff <= res_stat_ff;
         rsp_bit_ff  <= res_bit_ff;
         rsp_free_ff <= free_ext[10:0];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_block = rsp_blk_ff;
   assign rsp_ch.status       = rsp_stat_ff;
   assign rsp_ch.bit_value    = rsp_bit_ff;
   assign rsp_ch.free_count   = rsp_free_ff;

`ifndef ASSERT_OFF
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_MAX)
      else $error("free count above map size");

   a_scan_needs_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cmd_ff == CMD_ALLOC && free_ff != '0))
      else $error("scan without a free block");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result word without a finished command");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESULT) |-> !mem_wr_en)
      else $error("map written outside a command");
`endif

endmodule

[hw/rtl/bba_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bba_first_zero.sv]
`timescale 1ns / 1ps
// Finds the lowest clear bit of one 64-bit map word, byte by byte.
// Depends on bba_pkg.
module bba_first_zero (
   input  logic [63:0]          word,
   output bba_pkg::bba_find_type find
);
   import bba_pkg::*;

   logic [BYTES_PER_WORD-1:0] full;
   logic [2:0]                pos [BYTES_PER_WORD];
   logic [2:0]                sel;

   // lowest clear bit inside each byte
   always_comb begin
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         full[b] = &word[b*BYTE_BITS +: BYTE_BITS];
         pos[b]  = '0;
         for (int j = BYTE_BITS - 1; j >= 0; j--) begin
            if (!word[b*BYTE_BITS + j]) begin
               pos[b] = 3'(j);
            end
         end
      end
   end

   // lowest byte that is not full
   always_comb begin
      sel = '0;
      for (int b = BYTES_PER_WORD - 1; b >= 0; b--) begin
         if (!full[b]) begin
            sel = 3'(b);
         end
      end
      find.found = ~&full;
      find.idx   = {sel, pos[sel]};
   end

endmodule
